// File: rtl/core/ssfb_pkg.sv
// Shared types and constants of the SPI target frame buffer.
`default_nettype none

package ssfb_pkg;

  localparam int FRAME_MAX_DEF = 64;
  localparam int LEN_PORT_W    = 7;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  localparam logic REG_IRQ_LEVEL = 1'b0;

  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_RECEIVING = 2'd1,
    MODE_SENDING   = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TX,
    ST_TX_WAIT,
    ST_RX,
    ST_REL,
    ST_LOAD,
    ST_ARM_RD,
    ST_ARM_WAIT,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/ssfb_resp_store.sv
// Response byte memory with per-entry valid bits that read as zero until written.
`default_nettype none

module ssfb_resp_store
  import ssfb_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF,
  localparam int IDX_W = $clog2(FRAME_MAX),
  localparam int LEN_W = $clog2(FRAME_MAX + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mem_ctl_t         ctl,
  input  wire logic             clr_en,
  input  wire logic [LEN_W-1:0] clr_len,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [7:0]       wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [7:0]       rd_data
);

  logic [7:0]           mem [FRAME_MAX];
  logic [FRAME_MAX-1:0] vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (clr_en) begin
        for (int i = 0; i < FRAME_MAX; i++) begin
          if (LEN_W'(i) < clr_len) begin
            vld[i] <= 1'b0;
          end
        end
      end
      if (ctl.wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ssfb_frame_store.sv
// Two-bank received frame memory: one bank fills while the other is published.
`default_nettype none

module ssfb_frame_store
  import ssfb_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF,
  localparam int IDX_W = $clog2(FRAME_MAX)
) (
  input  wire logic           clk,
  input  wire mem_ctl_t       ctl,
  input  wire logic [IDX_W:0] wr_addr,
  input  wire logic [7:0]     wr_data,
  input  wire logic [IDX_W:0] rd_addr,
  output logic      [7:0]     rd_data
);

  logic [7:0] mem [2**(IDX_W+1)];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ssfb_ctrl.sv
// Sequencer, link state registers and result register of the frame buffer.
`default_nettype none

module ssfb_ctrl
  import ssfb_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF,
  localparam int IDX_W = $clog2(FRAME_MAX),
  localparam int LEN_W = $clog2(FRAME_MAX + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  irq_level,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire logic [1:0]            cmd,
  input  wire logic                  tx_ready_flag,
  input  wire logic                  rx_ready_flag,
  input  wire logic                  select_release_flag,
  input  wire logic [7:0]            rx_byte,
  input  wire logic [7:0]            load_byte,
  input  wire logic                  load_last,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic                       tdr_write,
  output logic [7:0]                 tdr_value,
  output logic                       tx_ready_irq_enable,
  output logic                       irq_pin,
  output logic                       frame_ready,
  output logic                       frame_byte_valid,
  output logic [7:0]                 frame_byte,
  output logic                       frame_last,
  output logic [LEN_PORT_W-1:0]      frame_length,
  output logic [1:0]                 link_mode
);

  ctrl_state_t state, state_next;

  logic             txr_q, rxr_q, rel_q, last_q;
  logic [7:0]       rxb_q, lb_q;
  logic [LEN_W-1:0] resp_len, resp_pos, load_count, work_len, cap_len, rd_idx;
  logic             armed, pending, tx_en, attention, wrote, wbank;
  mode_t            mode;
  logic [7:0]       tdr_last;

  mem_ctl_t         resp_ctl, frame_ctl;
  logic             resp_clr;
  logic [IDX_W-1:0] resp_wr_addr, resp_rd_addr;
  logic [7:0]       resp_rd_data, frame_rd_data;
  logic [IDX_W:0]   frame_wr_addr, frame_rd_addr;

  logic             out_free, emit_status, emit_byte;
  logic             accept;
  logic             can_send, rd_last, read_hit, load_fits, wr_ok, publish, finish;
  logic [LEN_W-1:0] wlen_eff, load_count_inc;

  ssfb_resp_store #(.FRAME_MAX(FRAME_MAX)) u_resp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (resp_ctl),
    .clr_en  (resp_clr),
    .clr_len (resp_len),
    .wr_addr (resp_wr_addr),
    .wr_data (lb_q),
    .rd_addr (resp_rd_addr),
    .rd_data (resp_rd_data)
  );

  ssfb_frame_store #(.FRAME_MAX(FRAME_MAX)) u_frame (
    .clk     (clk),
    .ctl     (frame_ctl),
    .wr_addr (frame_wr_addr),
    .wr_data (rxb_q),
    .rd_addr (frame_rd_addr),
    .rd_data (frame_rd_data)
  );

  assign item_ready     = (state == ST_IDLE);
  assign accept         = item_valid && item_ready;
  assign out_free       = !result_valid || result_ready;
  assign can_send       = armed && (resp_pos < resp_len);
  assign rd_last        = (rd_idx + LEN_W'(1)) == cap_len;
  assign read_hit       = pending && (cap_len != '0);
  assign load_fits      = load_count < LEN_W'(FRAME_MAX);
  assign load_count_inc = load_fits ? load_count + LEN_W'(1) : load_count;
  assign wlen_eff       = (mode != MODE_RECEIVING) ? '0 : work_len;
  assign wr_ok          = wlen_eff < LEN_W'(FRAME_MAX);
  assign publish        = (mode == MODE_RECEIVING) && (work_len != '0);
  assign finish         = armed && (resp_pos >= resp_len);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_STATUS: state_next = ST_TX;
            CMD_LOAD:   state_next = ST_LOAD;
            CMD_READ:   state_next = read_hit ? ST_RD_ISSUE : ST_EMIT;
            default:    state_next = ST_EMIT;
          endcase
        end
      end
      ST_TX:       state_next = (txr_q && can_send) ? ST_TX_WAIT : ST_RX;
      ST_TX_WAIT:  state_next = ST_RX;
      ST_RX:       state_next = ST_REL;
      ST_REL:      state_next = ST_EMIT;
      ST_LOAD:     state_next = last_q ? ST_ARM_RD : ST_EMIT;
      ST_ARM_RD:   state_next = ST_ARM_WAIT;
      ST_ARM_WAIT: state_next = ST_EMIT;
      ST_RD_ISSUE: state_next = ST_RD_WAIT;
      ST_RD_WAIT: begin
        if (out_free) begin
          state_next = rd_last ? ST_IDLE : ST_RD_ISSUE;
        end
      end
      ST_EMIT:     state_next = out_free ? ST_IDLE : ST_EMIT;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    resp_ctl      = '0;
    frame_ctl     = '0;
    resp_clr      = 1'b0;
    resp_wr_addr  = load_count[IDX_W-1:0];
    resp_rd_addr  = resp_pos[IDX_W-1:0];
    frame_wr_addr = {wbank, wlen_eff[IDX_W-1:0]};
    frame_rd_addr = {~wbank, rd_idx[IDX_W-1:0]};
    emit_status   = 1'b0;
    emit_byte     = 1'b0;
    unique case (state)
      ST_TX:      resp_ctl.rd_en = txr_q && can_send;
      ST_RX:      frame_ctl.wr_en = rxr_q && !armed && wr_ok;
      ST_REL:     resp_clr = rel_q && finish;
      ST_LOAD:    resp_ctl.wr_en = load_fits;
      ST_ARM_RD: begin
        resp_ctl.rd_en = 1'b1;
        resp_rd_addr   = '0;
      end
      ST_RD_ISSUE: frame_ctl.rd_en = 1'b1;
      ST_RD_WAIT:  emit_byte = out_free;
      ST_EMIT:     emit_status = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      txr_q  <= tx_ready_flag;
      rxr_q  <= rx_ready_flag;
      rel_q  <= select_release_flag;
      rxb_q  <= rx_byte;
      lb_q   <= load_byte;
      last_q <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      resp_len   <= '0;
      resp_pos   <= '0;
      load_count <= '0;
      work_len   <= '0;
      cap_len    <= '0;
      rd_idx     <= '0;
      armed      <= 1'b0;
      pending    <= 1'b0;
      tx_en      <= 1'b0;
      attention  <= 1'b0;
      wrote      <= 1'b0;
      wbank      <= 1'b0;
      mode       <= MODE_IDLE;
      tdr_last   <= 8'h00;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            wrote  <= 1'b0;
            rd_idx <= '0;
            if (cmd == CMD_READ) begin
              pending <= 1'b0;
            end
          end
        end
        ST_TX: begin
          if (txr_q && !can_send) begin
            tx_en <= 1'b0;
          end
        end
        ST_TX_WAIT: begin
          tdr_last <= resp_rd_data;
          wrote    <= 1'b1;
          resp_pos <= resp_pos + LEN_W'(1);
        end
        ST_RX: begin
          if (rxr_q) begin
            if (armed) begin
              mode <= MODE_SENDING;
            end else begin
              mode     <= MODE_RECEIVING;
              work_len <= wr_ok ? wlen_eff + LEN_W'(1) : wlen_eff;
              tdr_last <= 8'h00;
              wrote    <= 1'b1;
            end
          end
        end
        ST_REL: begin
          if (rel_q) begin
            if (publish) begin
              cap_len  <= work_len;
              pending  <= 1'b1;
              work_len <= '0;
              wbank    <= ~wbank;
            end
            if (finish) begin
              tx_en     <= 1'b0;
              armed     <= 1'b0;
              resp_len  <= '0;
              resp_pos  <= '0;
              tdr_last  <= 8'h00;
              wrote     <= 1'b1;
              attention <= 1'b0;
            end
            mode <= MODE_IDLE;
          end
        end
        ST_LOAD: begin
          if (last_q) begin
            resp_len   <= load_count_inc;
            resp_pos   <= LEN_W'(1);
            armed      <= 1'b1;
            mode       <= MODE_SENDING;
            tx_en      <= 1'b1;
            attention  <= 1'b1;
            load_count <= '0;
          end else begin
            load_count <= load_count_inc;
          end
        end
        ST_ARM_WAIT: begin
          tdr_last <= resp_rd_data;
          wrote    <= 1'b1;
        end
        ST_RD_WAIT: begin
          if (out_free) begin
            rd_idx <= rd_idx + LEN_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_status || emit_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_status || emit_byte) begin
      tdr_write           <= wrote;
      tdr_value           <= tdr_last;
      tx_ready_irq_enable <= tx_en;
      irq_pin             <= attention ? irq_level : ~irq_level;
      frame_ready         <= pending;
      link_mode           <= mode;
      frame_byte_valid    <= emit_byte;
      frame_byte          <= emit_byte ? frame_rd_data : 8'h00;
      frame_last          <= emit_byte ? rd_last : 1'b1;
      frame_length        <= emit_byte ? LEN_PORT_W'(cap_len) : '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/spi_slave_frame_buffer.sv
// Top level of the SPI target frame buffer with its configuration register.
`default_nettype none

// One transaction on the item channel is handled at a time. A status event
// passes TX, RX, REL and EMIT, with TX_WAIT after TX when a response byte is
// fetched from the response memory. A response load passes LOAD and EMIT, the
// last byte ARM_RD and ARM_WAIT in between. A frame read passes RD_ISSUE and
// RD_WAIT for each frame byte; a read with nothing pending or an unused command
// goes straight to EMIT. The frame and response memories have registered reads,
// and the status steps handle the flags in turn. The sequencer waits in EMIT or
// RD_WAIT while the consumer holds the result register. The irq_level register
// is decoded at byte addresses 0 to 3 and resets to 1.
module spi_slave_frame_buffer
  import ssfb_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_AW-1:0]     paddr,
  input  wire logic [APB_DW-1:0]     pwdata,
  output logic      [APB_DW-1:0]     prdata,
  output logic                       pready,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire logic [1:0]            cmd,
  input  wire logic                  tx_ready_flag,
  input  wire logic                  rx_ready_flag,
  input  wire logic                  select_release_flag,
  input  wire logic [7:0]            rx_byte,
  input  wire logic [7:0]            load_byte,
  input  wire logic                  load_last,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic                       tdr_write,
  output logic [7:0]                 tdr_value,
  output logic                       tx_ready_irq_enable,
  output logic                       irq_pin,
  output logic                       frame_ready,
  output logic                       frame_byte_valid,
  output logic [7:0]                 frame_byte,
  output logic                       frame_last,
  output logic [LEN_PORT_W-1:0]      frame_length,
  output logic [1:0]                 link_mode
);

  logic irq_level;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1] == REG_IRQ_LEVEL);
  assign prdata  = reg_sel ? {{(APB_DW-1){1'b0}}, irq_level} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_level <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      irq_level <= pwdata[0];
    end
  end

  ssfb_ctrl #(.FRAME_MAX(FRAME_MAX)) u_ctrl (
    .clk                 (clk),
    .rst                 (rst),
    .irq_level           (irq_level),
    .item_valid          (item_valid),
    .item_ready          (item_ready),
    .cmd                 (cmd),
    .tx_ready_flag       (tx_ready_flag),
    .rx_ready_flag       (rx_ready_flag),
    .select_release_flag (select_release_flag),
    .rx_byte             (rx_byte),
    .load_byte           (load_byte),
    .load_last           (load_last),
    .result_valid        (result_valid),
    .result_ready        (result_ready),
    .tdr_write           (tdr_write),
    .tdr_value           (tdr_value),
    .tx_ready_irq_enable (tx_ready_irq_enable),
    .irq_pin             (irq_pin),
    .frame_ready         (frame_ready),
    .frame_byte_valid    (frame_byte_valid),
    .frame_byte          (frame_byte),
    .frame_last          (frame_last),
    .frame_length        (frame_length),
    .link_mode           (link_mode)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while another transaction was in progress");

  a_byte_has_length: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_byte_valid |-> frame_length != '0)
    else $error("frame byte result without a frame length");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !frame_byte_valid |-> frame_last && frame_length == '0)
    else $error("status result not marked as the end of its run");

  a_read_clears_ready: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_byte_valid |-> !frame_ready)
    else $error("frame still flagged as pending while it is being read");
`endif

endmodule

`default_nettype wire
